### hdl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/pcmwc_pkg.sv
package pcmwc_pkg;

   typedef enum logic [1:0] {
      CSR_SRC_BYTES  = 2'd0,
      CSR_DST_BYTES  = 2'd1,
      CSR_SRC_STEREO = 2'd2,
      CSR_DST_STEREO = 2'd3
   } csr_index_type;

   localparam logic [2:0] SRC_BYTES_RESET  = 3'd2;
   localparam logic [2:0] DST_BYTES_RESET  = 3'd2;
   localparam logic       SRC_STEREO_RESET = 1'b1;
   localparam logic       DST_STEREO_RESET = 1'b1;

   // one converted sample handed to the byte emitter
   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  last_idx;
      logic        chan;
      logic        dup;
   } emit_load_type;

   function automatic logic [2:0] clamp_width(input logic [2:0] w);
      logic [2:0] r;
      r = w;
      if (w == 3'd0) begin
         r = 3'd1;
      end else if (w > 3'd4) begin
         r = 3'd4;
      end
      return r;
   endfunction

endpackage

### hdl/pcmwc_req_if.sv
interface pcmwc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

### hdl/pcmwc_rsp_if.sv
interface pcmwc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_channel;
   logic       last;

   modport source (output valid, output out_byte, output out_channel, output last,
                   input ready);
   modport sink (input valid, input out_byte, input out_channel, input last,
                 output ready);
endinterface

### hdl/pcmwc_emit.sv
`include "assert_macros.svh"

module pcmwc_emit
   import pcmwc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load_valid,
   input  emit_load_type load,
   output logic          can_load,
   pcmwc_rsp_if.source   rsp_if
);

   logic        busy_ff, busy_in;
   logic [1:0]  idx_ff, idx_in;
   logic        dup_ff, dup_in;
   logic [31:0] value_ff, value_in;
   logic [1:0]  last_idx_ff, last_idx_in;
   logic        chan_ff, chan_in;

   logic end_of_sample;
   logic final_beat;
   logic fire;

   assign end_of_sample = (idx_ff == last_idx_ff);
   assign final_beat    = busy_ff && end_of_sample && !dup_ff;
   assign fire          = busy_ff && rsp_if.ready;
   assign can_load      = !busy_ff || (rsp_if.ready && final_beat);

   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      dup_in      = dup_ff;
      value_in    = value_ff;
      last_idx_in = last_idx_ff;
      chan_in     = chan_ff;
      if (fire) begin
         if (end_of_sample) begin
            if (dup_ff) begin
               // repeat the left sample on the right channel
               idx_in  = 2'd0;
               chan_in = 1'b1;
               dup_in  = 1'b0;
            end else begin
               busy_in = 1'b0;
            end
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load_valid) begin
         busy_in     = 1'b1;
         idx_in      = 2'd0;
         dup_in      = load.dup;
         value_in    = load.value;
         last_idx_in = load.last_idx;
         chan_in     = load.chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
         dup_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         dup_ff  <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      last_idx_ff <= last_idx_in;
      chan_ff     <= chan_in;
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_if.out_byte = value_ff[7:0];
         2'd1:    rsp_if.out_byte = value_ff[15:8];
         2'd2:    rsp_if.out_byte = value_ff[23:16];
         2'd3:    rsp_if.out_byte = value_ff[31:24];
         default: rsp_if.out_byte = value_ff[7:0];
      endcase
   end

   assign rsp_if.valid       = busy_ff;
   assign rsp_if.out_channel = chan_ff;
   assign rsp_if.last        = final_beat;

   `ASSERT_IMP(a_load_when_free, clock, reset, load_valid, can_load, "load while emitter busy")
   `ASSERT_IMP(a_dup_on_left, clock, reset, busy_ff && dup_ff, !chan_ff, "duplicate pending on right")
   `ASSERT_IMP(a_idx_in_range, clock, reset, busy_ff, idx_ff <= last_idx_ff, "byte index past sample")
   `ASSERT_NXT(a_drain_idle, clock, reset, fire && final_beat && !load_valid, !busy_ff, "emitter stuck busy")

endmodule

### hdl/pcm_width_channel_converter.sv
// PCM sample width and channel converter.
// req_if carries one source byte per item (little-endian samples, left before right).
// rsp_if carries one destination byte per item with its channel and a last flag that
// marks the final byte produced for one source sample.
// csr_we/csr_index/csr_wdata write src_bytes, dst_bytes, src_stereo, dst_stereo;
// write them only while no output is pending.
// Latency: the byte that completes a sample is converted in the accept cycle and its
// first output byte is presented on rsp_if in the next cycle.
// Throughput: one input byte per cycle while no output is pending. A finished sample
// occupies the output register for its dst_bytes bytes (twice as many when a mono left
// sample is duplicated), one output byte per cycle while the receiver is ready; bytes
// that do not complete a sample are still taken meanwhile, and a completing byte is
// taken in the cycle the last output byte of the previous burst leaves.
// Reset: registers return to 16-bit stereo in and out, partial sample and channel phase
// cleared. When the receiver stalls, the output byte holds and input stalls as soon as
// the next sample completes.
module pcm_width_channel_converter
   import pcmwc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_wdata,
   pcmwc_req_if.sink   req_if,
   pcmwc_rsp_if.source rsp_if
);

   logic [2:0]  src_bytes_ff;
   logic [2:0]  dst_bytes_ff;
   logic        src_stereo_ff;
   logic        dst_stereo_ff;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  count_ff, count_in;
   logic        right_ff, right_in;

   logic [2:0]    sb;
   logic [2:0]    db;
   logic [2:0]    pos_next;
   logic          complete;
   logic          accept;
   logic [31:0]   acc_new;
   logic [1:0]    up_diff;
   logic [1:0]    down_diff;
   logic [31:0]   value;
   logic          emit;
   logic          right_next;
   logic          can_load;
   logic          load_valid;
   emit_load_type load;

   assign sb        = clamp_width(src_bytes_ff);
   assign db        = clamp_width(dst_bytes_ff);
   assign pos_next  = {1'b0, count_ff} + 3'd1;
   assign complete  = (pos_next >= sb);
   assign req_if.ready = can_load || !complete;
   assign accept    = req_if.valid && req_if.ready;
   assign acc_new   = acc_ff | (32'(req_if.data_byte) << {count_ff, 3'b000});
   assign up_diff   = 2'(db - sb);
   assign down_diff = 2'(sb - db);

   always_comb begin
      if (db > sb) begin
         value = acc_new << {up_diff, 3'b000};
      end else begin
         value = acc_new >> {down_diff, 3'b000};
      end
   end

   always_comb begin
      load.value    = value;
      load.last_idx = 2'(db - 3'd1);
      if (!right_ff) begin
         emit       = 1'b1;
         load.chan  = 1'b0;
         load.dup   = !src_stereo_ff && dst_stereo_ff;
         right_next = src_stereo_ff;
      end else begin
         emit       = dst_stereo_ff;
         load.chan  = 1'b1;
         load.dup   = 1'b0;
         right_next = 1'b0;
      end
   end

   assign load_valid = accept && complete && emit;

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      right_in = right_ff;
      if (accept) begin
         if (complete) begin
            acc_in   = 32'd0;
            count_in = 2'd0;
            right_in = right_next;
         end else begin
            acc_in   = acc_new;
            count_in = pos_next[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_bytes_ff  <= SRC_BYTES_RESET;
         dst_bytes_ff  <= DST_BYTES_RESET;
         src_stereo_ff <= SRC_STEREO_RESET;
         dst_stereo_ff <= DST_STEREO_RESET;
         acc_ff        <= 32'd0;
         count_ff      <= 2'd0;
         right_ff      <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         right_ff <= right_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_BYTES:  src_bytes_ff  <= csr_wdata;
               CSR_DST_BYTES:  dst_bytes_ff  <= csr_wdata;
               CSR_SRC_STEREO: src_stereo_ff <= csr_wdata[0];
               CSR_DST_STEREO: dst_stereo_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   pcmwc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load       (load),
      .can_load   (can_load),
      .rsp_if     (rsp_if)
   );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import pcmwc_pkg::*;

   localparam int HOLD_CYCLES = 250;
   localparam int STALL_LIMIT = 3000;
   localparam int N_PHASES    = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_channel;
      logic       last;
   } pcm_out_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [2:0] csr_wdata;

   pcmwc_req_if req_if();
   pcmwc_rsp_if rsp_if();

   pcm_width_channel_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   // converter state and registers as the testbench sees them
   logic [2:0]  cfg_src_bytes  = SRC_BYTES_RESET;
   logic [2:0]  cfg_dst_bytes  = DST_BYTES_RESET;
   logic        cfg_src_stereo = SRC_STEREO_RESET;
   logic        cfg_dst_stereo = DST_STEREO_RESET;
   logic [31:0] acc_sample     = '0;
   logic [1:0]  acc_count      = '0;
   logic        in_right       = 1'b0;

   logic [7:0]  byte_pend[$];
   pcm_out_type out_expected[$];

   int mismatches    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_width(input logic [2:0] w);
      if (w == 3'd0) return 1;
      if (w > 3'd4) return 4;
      return int'(w);
   endfunction

   task automatic convert_byte(input logic [7:0] b);
      int          sb;
      int          db;
      int          pos;
      int          total;
      int          k;
      int          n;
      logic [31:0] val;
      logic        emit_l;
      logic        emit_r;
      pcm_out_type o;
      sb  = eff_width(cfg_src_bytes);
      db  = eff_width(cfg_dst_bytes);
      pos = int'(acc_count);
      acc_sample = acc_sample | ({24'd0, b} << (8 * pos));
      if (pos + 1 < sb) begin
         acc_count = 2'(pos + 1);
         return;
      end
      val = acc_sample;
      if (db > sb) begin
         val = val << (8 * (db - sb));
      end else begin
         val = val >> (8 * (sb - db));
      end
      acc_sample = '0;
      acc_count  = '0;
      emit_l = 1'b0;
      emit_r = 1'b0;
      if (!in_right) begin
         emit_l = 1'b1;
         if (cfg_src_stereo) begin
            in_right = 1'b1;
         end else if (cfg_dst_stereo) begin
            emit_r = 1'b1;
         end
      end else begin
         in_right = 1'b0;
         emit_r   = cfg_dst_stereo;
      end
      total = db * (int'(emit_l) + int'(emit_r));
      n = 0;
      for (k = 0; k < total; k++) begin
         o.out_byte    = 8'((val >> (8 * (k % db))) & 32'hFF);
         o.out_channel = (emit_l && k < db) ? 1'b0 : 1'b1;
         o.last        = (n == total - 1);
         out_expected.push_back(o);
         n++;
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (byte_pend.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_if.valid     <= 1'b1;
            req_if.data_byte <= byte_pend.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver, with the long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served  <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // output check, then prediction for the accepted item, then register writes
   always @(posedge clock) begin : mon_blk
      pcm_out_type got;
      pcm_out_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.out_byte, rsp_if.out_channel, rsp_if.last};
            if (out_expected.size() == 0) begin
               mismatches++;
               $display("%0t: expected no item, got byte=%02h ch=%0d last=%0d", $time,
                        got.out_byte, got.out_channel, got.last);
            end else begin
               want = out_expected.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected byte=%02h ch=%0d last=%0d, got byte=%02h ch=%0d last=%0d",
                           $time, want.out_byte, want.out_channel, want.last,
                           got.out_byte, got.out_channel, got.last);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            convert_byte(req_if.data_byte);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_BYTES:  cfg_src_bytes  = csr_wdata;
               CSR_DST_BYTES:  cfg_dst_bytes  = csr_wdata;
               CSR_SRC_STEREO: cfg_src_stereo = csr_wdata[0];
               CSR_DST_STEREO: cfg_dst_stereo = csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** pcm_width_channel_converter: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [2:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic setup(input logic [2:0] sb, input logic [2:0] db,
                        input logic ss, input logic ds);
      write_reg(CSR_SRC_BYTES, sb);
      write_reg(CSR_DST_BYTES, db);
      write_reg(CSR_SRC_STEREO, {2'b00, ss});
      write_reg(CSR_DST_STEREO, {2'b00, ds});
   endtask

   // checked away from the rising edge so that all updates of the cycle have settled
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (byte_pend.size() != 0 || req_if.valid || out_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic send(input logic [7:0] bytes[]);
      foreach (bytes[i]) byte_pend.push_back(bytes[i]);
      wait_drained();
   endtask

   function automatic logic [2:0] pick_width();
      int r;
      r = $urandom_range(0, 15);
      if (r < 12) return 3'(1 + r % 4);
      if (r == 12) return 3'd0;
      return 3'(r - 8);
   endfunction

   initial begin : main_blk
      int p;
      int n;
      int mode;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      rsp_if.ready     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset settings, then widening with mono duplicated to both channels
      send('{8'h00, 8'h80, 8'hFF, 8'h7F});
      setup(3'd1, 3'd4, 1'b0, 1'b1);
      send('{8'hFF, 8'h00, 8'h80, 8'h01});
      // narrowing, stereo to mono drops the right sample
      setup(3'd4, 3'd1, 1'b1, 1'b0);
      send('{8'h11, 8'h22, 8'h33, 8'h44, 8'hAA, 8'hBB, 8'hCC, 8'hDD});
      // width codes out of range
      setup(3'd0, 3'd7, 1'b1, 1'b1);
      send('{8'h96, 8'h69});
      // width shrinks with a sample half gathered
      setup(3'd4, 3'd2, 1'b1, 1'b1);
      send('{8'h5A, 8'hA5});
      write_reg(CSR_SRC_BYTES, 3'd2);
      repeat (2) @(posedge clock);
      send('{8'hC3});
      // source goes mono while a right sample is due
      write_reg(CSR_SRC_STEREO, 3'd0);
      repeat (2) @(posedge clock);
      send('{8'h34, 8'h12, 8'h00, 8'hFF});

      for (p = 0; p < N_PHASES; p++) begin
         if (p == 0) begin
            setup(3'd4, 3'd4, 1'b0, 1'b1);
         end else if (p == 1) begin
            setup(3'd1, 3'd1, 1'b1, 1'b0);
         end else begin
            setup(pick_width(), pick_width(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
         end
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 68 : (mode == 3) ? 12 : 0;
         stall_pct     = (mode == 2) ? 68 : (mode == 3) ? 12 : 0;
         if (p == 4) begin
            @(posedge clock);
            hold_requests <= hold_requests + 1;
         end
         n = $urandom_range(16, 26);
         repeat (n) byte_pend.push_back(8'($urandom_range(0, 255)));
         wait_drained();
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && out_expected.size() == 0) begin
         $display("** pcm_width_channel_converter: PASSED **");
      end else begin
         $display("** pcm_width_channel_converter: FAILED **");
      end
      $finish;
   end

endmodule
